// ===== rtl/imh_pkg.sv =====
package imh_pkg;

    localparam int CAPACITY     = 256;
    localparam int VERTEX_COUNT = 256;
    localparam int DIST_WIDTH   = 32;
    localparam int VERT_WIDTH   = 8;
    localparam int ADDR_WIDTH   = $clog2(CAPACITY);
    localparam int POS_WIDTH    = $clog2(CAPACITY + 1);
    localparam int VADDR_WIDTH  = $clog2(VERTEX_COUNT);

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_DEC  = 2'd2;
    localparam logic [1:0] FUNC_NOP  = 2'd3;

    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_NOT_SMALLER = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_EMPTY       = 3'd3;
    localparam logic [2:0] ST_ABSENT      = 3'd4;

    typedef struct packed {
        logic [1:0]            func;
        logic [VERT_WIDTH-1:0] vertex;
        logic [DIST_WIDTH-1:0] distance;
    } t_in;

    typedef struct packed {
        logic [2:0]            status;
        logic [VERT_WIDTH-1:0] top_vertex;
        logic [DIST_WIDTH-1:0] top_distance;
        logic                  is_empty;
        logic [POS_WIDTH-1:0]  entry_count;
    } t_out;

    typedef struct packed {
        logic [VERT_WIDTH-1:0] vert;
        logic [DIST_WIDTH-1:0] key;
    } t_ent;

    typedef struct packed {
        logic                  en;
        logic [ADDR_WIDTH-1:0] addr;
        t_ent                  data;
    } t_heap_wr;

    typedef struct packed {
        logic                   en;
        logic [VADDR_WIDTH-1:0] addr;
        logic [POS_WIDTH-1:0]   data;
    } t_map_wr;

endpackage

// ===== rtl/imh_heap_ram.sv =====
module imh_heap_ram (
    input  logic                              i_clk,
    input  imh_pkg::t_heap_wr                 i_wr,
    input  logic [imh_pkg::ADDR_WIDTH-1:0]    i_raddr,
    output imh_pkg::t_ent                     o_rdata
);
    import imh_pkg::*;

    t_ent r_mem [CAPACITY];
    t_ent r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== rtl/imh_pos_map.sv =====
module imh_pos_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  imh_pkg::t_map_wr                  i_wr,
    input  logic [imh_pkg::VADDR_WIDTH-1:0]   i_raddr,
    output logic [imh_pkg::POS_WIDTH-1:0]     o_rdata
);
    import imh_pkg::*;

    logic [POS_WIDTH-1:0]    r_mem [VERTEX_COUNT];
    logic [VERTEX_COUNT-1:0] r_vld;
    logic [POS_WIDTH-1:0]    r_q;
    logic                    r_qv;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_q <= r_mem[i_raddr];
    end

    // an entry never written reads as absent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_qv  <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            r_qv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_qv ? r_q : '0;

endmodule

// ===== rtl/indexed_min_heap_decrease_key.sv =====
// channel | direction | handshake                 | beat
// in      | input     | i_in_valid / o_in_stall   | t_in  {func, vertex, distance}
// out     | output    | o_out_valid / i_out_stall | t_out {status, top, empty, count}
// A pop walks down the heap level by level, with two reads of the single heap read
// port plus compares per level; a push or decrease key walks up level by level.
// Reset is synchronous; the position map valid bits clear at once, no sweep.
// A new beat is taken while a result waits on a stalled output register.
module indexed_min_heap_decrease_key (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  imh_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output imh_pkg::t_out o_out
);
    import imh_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MAP   = 4'd1;
    localparam logic [3:0] S_LK    = 4'd2;
    localparam logic [3:0] S_SU    = 4'd3;
    localparam logic [3:0] S_SUCHK = 4'd4;
    localparam logic [3:0] S_POP1  = 4'd5;
    localparam logic [3:0] S_POP2  = 4'd6;
    localparam logic [3:0] S_SD    = 4'd7;
    localparam logic [3:0] S_SDL   = 4'd8;
    localparam logic [3:0] S_SDR   = 4'd9;
    localparam logic [3:0] S_SDDEC = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_FRD   = 4'd12;

    logic [3:0]           r_state, n_state;
    logic [POS_WIDTH-1:0] r_cnt, n_cnt;
    logic [POS_WIDTH-1:0] r_cur, n_cur;
    logic [POS_WIDTH-1:0] r_best, n_best;
    logic [2:0]           r_st, n_st;
    t_in                  r_in, n_in;
    t_ent                 r_e, n_e;
    t_ent                 r_c, n_c;
    logic                 r_ovalid, n_ovalid;
    t_out                 r_out, n_out;

    t_heap_wr             w_hwr;
    t_map_wr              w_mwr;
    logic [ADDR_WIDTH-1:0]  w_hra;
    logic [VADDR_WIDTH-1:0] w_mra;
    t_ent                 w_hq;
    logic [POS_WIDTH-1:0] w_mq;
    logic [POS_WIDTH:0]   w_l;
    logic [POS_WIDTH:0]   w_r;
    logic [POS_WIDTH-1:0] w_cm1;
    logic                 w_out_free;

    imh_heap_ram u_heap (
        .i_clk   (i_clk),
        .i_wr    (w_hwr),
        .i_raddr (w_hra),
        .o_rdata (w_hq)
    );

    imh_pos_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_mwr),
        .i_raddr (w_mra),
        .o_rdata (w_mq)
    );

    assign w_l        = {r_cur, 1'b0};
    assign w_r        = w_l + 1'b1;
    assign w_cm1      = r_cur - 1'b1;
    assign w_out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_best   = r_best;
        n_st     = r_st;
        n_in     = r_in;
        n_e      = r_e;
        n_c      = r_c;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        w_hwr    = '0;
        w_mwr    = '0;
        w_hra    = '0;
        w_mra    = i_in.vertex;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in;
                    n_st = ST_DONE;
                    n_e  = '{vert: i_in.vertex, key: i_in.distance};
                    if (i_in.func == FUNC_POP) begin
                        if (r_cnt == '0) begin
                            n_st    = ST_EMPTY;
                            n_state = S_FIN;
                        end else begin
                            n_state = S_POP1;
                        end
                    end else if (i_in.func == FUNC_PUSH || i_in.func == FUNC_DEC) begin
                        n_state = S_MAP;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MAP: begin
                if (w_mq != '0 && w_mq <= r_cnt) begin
                    w_hra   = ADDR_WIDTH'(w_mq - 1'b1);
                    n_cur   = w_mq;
                    n_state = S_LK;
                end else if (r_in.func == FUNC_DEC || w_mq != '0) begin
                    n_st    = ST_ABSENT;
                    n_state = S_FIN;
                end else if (r_cnt >= POS_WIDTH'(CAPACITY)) begin
                    n_st    = ST_FULL;
                    n_state = S_FIN;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_cur   = r_cnt + 1'b1;
                    n_state = S_SU;
                end
            end
            S_LK: begin
                if (r_e.key < w_hq.key) begin
                    n_state = S_SU;
                end else begin
                    n_st    = ST_NOT_SMALLER;
                    n_state = S_FIN;
                end
            end
            S_SU: begin
                if (r_cur == POS_WIDTH'(1)) begin
                    w_hwr   = '{en: 1'b1, addr: w_cm1[ADDR_WIDTH-1:0], data: r_e};
                    w_mwr   = '{en: 1'b1, addr: r_e.vert, data: r_cur};
                    n_state = S_FIN;
                end else begin
                    w_hra   = ADDR_WIDTH'((r_cur >> 1) - 1'b1);
                    n_state = S_SUCHK;
                end
            end
            S_SUCHK: begin
                if (r_e.key < w_hq.key) begin
                    // move the parent down, keep the rising entry in r_e
                    w_hwr   = '{en: 1'b1, addr: w_cm1[ADDR_WIDTH-1:0], data: w_hq};
                    w_mwr   = '{en: 1'b1, addr: w_hq.vert, data: r_cur};
                    n_cur   = r_cur >> 1;
                    n_state = S_SU;
                end else begin
                    w_hwr   = '{en: 1'b1, addr: w_cm1[ADDR_WIDTH-1:0], data: r_e};
                    w_mwr   = '{en: 1'b1, addr: r_e.vert, data: r_cur};
                    n_state = S_FIN;
                end
            end
            S_POP1: begin
                // w_hq holds the root here
                w_mwr   = '{en: 1'b1, addr: w_hq.vert, data: '0};
                w_hra   = ADDR_WIDTH'(r_cnt - 1'b1);
                n_state = S_POP2;
            end
            S_POP2: begin
                n_e   = w_hq;
                n_cnt = r_cnt - 1'b1;
                n_cur = POS_WIDTH'(1);
                if (r_cnt == POS_WIDTH'(1)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SD;
                end
            end
            S_SD: begin
                if (w_l > {1'b0, r_cnt}) begin
                    w_hwr   = '{en: 1'b1, addr: w_cm1[ADDR_WIDTH-1:0], data: r_e};
                    w_mwr   = '{en: 1'b1, addr: r_e.vert, data: r_cur};
                    n_state = S_FIN;
                end else begin
                    w_hra   = ADDR_WIDTH'(w_l - 1'b1);
                    n_state = S_SDL;
                end
            end
            S_SDL: begin
                n_c    = w_hq;
                n_best = w_l[POS_WIDTH-1:0];
                if (w_r <= {1'b0, r_cnt}) begin
                    w_hra   = w_l[ADDR_WIDTH-1:0];
                    n_state = S_SDR;
                end else begin
                    n_state = S_SDDEC;
                end
            end
            S_SDR: begin
                // left wins a tie
                if (w_hq.key < r_c.key) begin
                    n_c    = w_hq;
                    n_best = w_r[POS_WIDTH-1:0];
                end
                n_state = S_SDDEC;
            end
            S_SDDEC: begin
                if (r_c.key < r_e.key) begin
                    w_hwr   = '{en: 1'b1, addr: w_cm1[ADDR_WIDTH-1:0], data: r_c};
                    w_mwr   = '{en: 1'b1, addr: r_c.vert, data: r_cur};
                    n_cur   = r_best;
                    n_state = S_SD;
                end else begin
                    w_hwr   = '{en: 1'b1, addr: w_cm1[ADDR_WIDTH-1:0], data: r_e};
                    w_mwr   = '{en: 1'b1, addr: r_e.vert, data: r_cur};
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_FRD;
            end
            S_FRD: begin
                // keep reading the root until the output register frees
                if (w_out_free) begin
                    n_ovalid          = 1'b1;
                    n_out.status      = r_st;
                    n_out.entry_count = r_cnt;
                    n_out.is_empty    = (r_cnt == '0);
                    n_out.top_vertex   = (r_cnt == '0) ? '0 : w_hq.vert;
                    n_out.top_distance = (r_cnt == '0) ? '0 : w_hq.key;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur  <= n_cur;
        r_best <= n_best;
        r_st   <= n_st;
        r_in   <= n_in;
        r_e    <= n_e;
        r_c    <= n_c;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= POS_WIDTH'(CAPACITY))
        else $error("entry count above capacity");

    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRD && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not posted after root read");

    a_sift_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SU || r_state == S_SD || r_state == S_SDDEC)
            |-> (r_cur != '0 && r_cur <= r_cnt))
        else $error("sift position out of range");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP2) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("pop did not drop the count");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import imh_pkg::*;

    localparam int LIMIT = 20000;

    // Heap model with vertex-to-position map; tracks the expected result beats.
    class heap_scoreboard;
        logic [VERT_WIDTH-1:0] hv [1:CAPACITY];
        logic [DIST_WIDTH-1:0] hd [1:CAPACITY];
        int                    pos [VERTEX_COUNT];
        int                    cnt;
        t_out                  pending[$];
        int                    errors;
        int                    checked;

        function void clear();
            foreach (pos[i]) pos[i] = 0;
            cnt = 0;
            pending.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic [VERT_WIDTH-1:0] tv;
            logic [DIST_WIDTH-1:0] td;
            tv = hv[a]; td = hd[a];
            hv[a] = hv[b]; hd[a] = hd[b];
            hv[b] = tv; hd[b] = td;
            pos[hv[a]] = a;
            pos[hv[b]] = b;
        endfunction

        function void raise(int p);
            while (p > 1 && hd[p] < hd[p/2]) begin
                swap_slots(p, p/2);
                p = p / 2;
            end
        endfunction

        function void sink(int p);
            int best;
            forever begin
                best = p;
                if (2*p <= cnt && hd[2*p] < hd[best]) best = 2*p;
                if (2*p+1 <= cnt && hd[2*p+1] < hd[best]) best = 2*p+1;
                if (best == p) return;
                swap_slots(p, best);
                p = best;
            end
        endfunction

        function logic [2:0] lower(int v, logic [DIST_WIDTH-1:0] d);
            int p;
            p = pos[v];
            if (p == 0 || p > cnt) return ST_ABSENT;
            if (!(d < hd[p])) return ST_NOT_SMALLER;
            hd[p] = d;
            raise(p);
            return ST_DONE;
        endfunction

        function void note_input(t_in b);
            t_out r;
            logic [2:0] st;
            st = ST_DONE;
            case (b.func)
                FUNC_PUSH: begin
                    if (pos[b.vertex] != 0) st = lower(b.vertex, b.distance);
                    else if (cnt >= CAPACITY) st = ST_FULL;
                    else begin
                        cnt++;
                        hv[cnt] = b.vertex;
                        hd[cnt] = b.distance;
                        pos[b.vertex] = cnt;
                        raise(cnt);
                    end
                end
                FUNC_POP: begin
                    if (cnt == 0) st = ST_EMPTY;
                    else begin
                        pos[hv[1]] = 0;
                        if (cnt > 1) begin
                            hv[1] = hv[cnt];
                            hd[1] = hd[cnt];
                            pos[hv[1]] = 1;
                        end
                        cnt--;
                        sink(1);
                    end
                end
                FUNC_DEC: st = lower(b.vertex, b.distance);
                default: ;
            endcase
            r.status = st;
            r.top_vertex = (cnt > 0) ? hv[1] : '0;
            r.top_distance = (cnt > 0) ? hd[1] : '0;
            r.is_empty = (cnt == 0);
            r.entry_count = POS_WIDTH'(cnt);
            pending.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch #%0d: expected st=%0d v=%0d d=%0d e=%0d n=%0d",
                             checked, want.status, want.top_vertex, want.top_distance,
                             want.is_empty, want.entry_count);
                    $display("    got st=%0d v=%0d d=%0d e=%0d n=%0d",
                             got.status, got.top_vertex, got.top_distance,
                             got.is_empty, got.entry_count);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    t_in  i_in = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    heap_scoreboard board;
    int  idle_cycles;
    int  items_sent;
    bit  calm;
    bit  hold_out;
    bit  sender_done;

    always #5 i_clk = ~i_clk;

    indexed_min_heap_decrease_key dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // Monitor: note accepted input beats and check accepted result beats.
    always @(posedge i_clk) begin : mon
        bit seen;
        seen = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_input(i_in);
                seen = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_result(o_out);
                seen = 1'b1;
            end
            idle_cycles <= seen ? 0 : idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= LIMIT) begin
            $display("watchdog expired, %0d results outstanding", board.pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, or a long hold-off on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_out = 1'b0;
                i_out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 8);
                i_out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_beat(input logic [1:0] f, input int v, input logic [31:0] d);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= '{func: f, vertex: v[7:0], distance: d};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_dist();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Pick a vertex that is most often present, to exercise decrease key.
    function automatic int pick_vertex();
        int v;
        if (board.cnt > 0 && $urandom_range(0, 3) != 0) return board.hv[$urandom_range(1, board.cnt)];
        v = $urandom_range(0, 255);
        return v;
    endfunction

    initial begin
        int phase;
        int mix;
        int f;
        board = new();
        board.clear();
        idle_cycles = 0;
        items_sent = 0;
        calm = 1'b0;
        hold_out = 1'b0;
        sender_done = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty pop, absent decrease, extremes, ties, duplicate push.
        send_beat(FUNC_POP, 0, 0);
        send_beat(FUNC_DEC, 5, 1);
        send_beat(FUNC_PUSH, 255, 32'hFFFF_FFFF);
        send_beat(FUNC_PUSH, 0, 32'h0);
        send_beat(FUNC_PUSH, 7, 32'h0);
        send_beat(FUNC_PUSH, 7, 32'h0);
        send_beat(FUNC_PUSH, 255, 32'hFFFF_FFFE);
        send_beat(FUNC_DEC, 255, 32'hFFFF_FFFF);
        send_beat(FUNC_DEC, 255, 32'h0);
        send_beat(FUNC_NOP, 170, 32'hAAAA_AAAA);
        send_beat(FUNC_DEC, 85, 32'h5555_5555);
        send_beat(FUNC_POP, 0, 0);
        send_beat(FUNC_POP, 0, 0);
        send_beat(FUNC_POP, 0, 0);
        send_beat(FUNC_POP, 0, 0);
        send_beat(FUNC_DEC, 0, 0);

        // Fill to capacity, push a present vertex again, decrease deep entries, then empty it.
        for (int v = 0; v < 256; v++) send_beat(FUNC_PUSH, v, $urandom);
        send_beat(FUNC_PUSH, 3, 32'hFFFF_FFFF);
        drain();
        for (int i = 0; i < 20; i++) send_beat(FUNC_DEC, pick_vertex(), $urandom_range(0, 100));
        hold_out = 1'b1;
        for (int i = 0; i < 30; i++) send_beat(FUNC_POP, 0, 0);
        drain();
        while (board.cnt > 0) send_beat(FUNC_POP, 0, 0);
        send_beat(FUNC_POP, 0, 0);

        // Random: mostly pushes and decreases on live vertices.
        for (int i = 0; i < 550; i++) begin
            if (i == 450) begin
                drain();
                calm = 1'b1;
            end
            mix = $urandom_range(0, 99);
            f = (mix < 40) ? FUNC_PUSH : (mix < 70) ? FUNC_POP : (mix < 97) ? FUNC_DEC : FUNC_NOP;
            send_beat(f[1:0], pick_vertex(), rand_dist());
        end

        drain();
        repeat (100) @(negedge i_clk);
        $display("Covered %0d beats, %0d results checked: full/empty heap, absent and",
                 items_sent, board.checked);
        $display("non-smaller decrease keys, duplicate pushes, ties and long output stalls.");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors", board.errors);
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
